[hw/rtl/cgi_pkg.sv]
// Shared types and constants for the color gradient interpolator.
package cgi_pkg;

    localparam int KEY_IN_W = 12;
    localparam int KEY_W    = 11;
    localparam int COLOR_W  = 32;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int PROD_W   = CH_W + KEY_W;
    localparam int DIVC_W   = $clog2(PROD_W);
    localparam int ENTRY_W  = KEY_W + COLOR_W;

    localparam logic [COLOR_W-1:0] WHITE = {COLOR_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FULL,
        RES_WHITE,
        RES_STOP,
        RES_BLEND
    } res_kind_t;

    typedef struct packed {
        logic      accept;
        logic      clear_count;
        logic      ins_start;
        logic      rd;
        logic      rd_prev;
        logic      ins_move;
        logic      ins_place;
        logic      qry_start;
        logic      qry_step;
        logic      mul;
        logic      div_step;
        logic      set_result;
        res_kind_t res_kind;
        logic      load_out;
    } cgi_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       idx_zero;
        logic       idx_last;
        logic       rd_gt;
        logic       rd_eq;
        logic       div_last;
        logic       out_free;
    } cgi_status_t;

endpackage

[hw/rtl/cgi_ctrl.sv]
// Controller state machine that sequences clear, insert and query beats.
module cgi_ctrl
    import cgi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  cgi_status_t status,
    output cgi_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_QRY_RD,
        ST_QRY_CMP,
        ST_DIV,
        ST_BLEND,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_kind = RES_ZERO;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.set_result = 1'b1;
                cmd.res_kind   = RES_ZERO;
                state_next     = ST_FINISH;
                case (status.op)
                    OP_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                    end
                    OP_INSERT:
                    begin
                        if (status.full)
                        begin
                            cmd.res_kind = RES_FULL;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = ST_INS_CHK;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (status.empty)
                        begin
                            cmd.res_kind = RES_WHITE;
                        end
                        else
                        begin
                            cmd.qry_start = 1'b1;
                            state_next    = ST_QRY_RD;
                        end
                    end
                    default:
                    begin
                        cmd.res_kind = RES_ZERO;
                    end
                endcase
            end
            ST_INS_CHK:
            begin
                if (status.idx_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                // Stops with a larger key move up one slot; equal keys stay below.
                if (status.rd_gt)
                begin
                    cmd.ins_move = 1'b1;
                    state_next   = ST_INS_CHK;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_QRY_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_QRY_RD == state_reg ? ST_QRY_CMP : state_reg;
            end
            ST_QRY_CMP:
            begin
                if (status.rd_eq || (status.rd_gt && status.idx_zero) ||
                    (!status.rd_gt && status.idx_last))
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = RES_STOP;
                    state_next     = ST_FINISH;
                end
                else if (status.rd_gt)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.qry_step = 1'b1;
                    state_next   = ST_QRY_RD;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                cmd.set_result = 1'b1;
                cmd.res_kind   = RES_BLEND;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/cgi_datapath.sv]
// Datapath: stop table memory, search pointer, channel multipliers and dividers.
module cgi_datapath
    import cgi_pkg::*;
#(
    parameter int MAX_STOPS = 16,
    parameter int KEY_SCALE = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 operation,
    input  logic signed [KEY_IN_W-1:0] key,
    input  logic [COLOR_W-1:0]         stop_color,
    input  logic                       result_stall,
    output logic                       result_valid,
    output logic [COLOR_W-1:0]         color,
    output logic                       status,
    input  cgi_cmd_t                   cmd,
    output cgi_status_t                stat
);

    localparam int CNT_W  = $clog2(MAX_STOPS + 1);
    localparam int ADDR_W = $clog2(MAX_STOPS);
    localparam int WIDE_W = KEY_IN_W + 2;
    localparam logic signed [WIDE_W-1:0] SCALE_S = WIDE_W'(KEY_SCALE);

    logic [ENTRY_W-1:0] mem [MAX_STOPS];

    logic [1:0]                 op_reg;
    logic signed [KEY_IN_W-1:0] key_reg;
    logic [COLOR_W-1:0]         col_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic [ENTRY_W-1:0]         rd_data_reg;
    logic [KEY_W-1:0]           prev_key_reg;
    logic [COLOR_W-1:0]         prev_color_reg;
    logic [KEY_W-1:0]           den_reg;
    logic [CH_W-1:0]            base_reg [NUM_CH];
    logic                       neg_reg  [NUM_CH];
    logic [PROD_W-1:0]          dvd_reg  [NUM_CH];
    logic [KEY_W-1:0]           rem_reg  [NUM_CH];
    logic [DIVC_W-1:0]          div_cnt_reg;
    logic [COLOR_W-1:0]         pend_color_reg;
    logic                       pend_status_reg;
    logic                       result_valid_reg;
    logic [COLOR_W-1:0]         color_reg;
    logic                       status_reg;

    logic signed [WIDE_W-1:0]   key_wide;
    logic signed [KEY_IN_W-1:0] key_clamped;
    logic [KEY_W-1:0]           rd_key;
    logic [COLOR_W-1:0]         rd_color;
    logic signed [KEY_IN_W-1:0] rd_key_s;
    logic [ADDR_W-1:0]          rd_addr;
    logic [CNT_W-1:0]           idx_dec;
    logic [KEY_W-1:0]           num;
    logic [KEY_W:0]             shifted  [NUM_CH];
    logic [KEY_W-1:0]           rem_next [NUM_CH];
    logic                       qbit     [NUM_CH];
    logic [COLOR_W-1:0]         blend_color;
    logic [COLOR_W-1:0]         res_color;
    logic                       res_status;

    assign key_wide = WIDE_W'(key);
    always_comb
    begin
        if (key_wide < 0)
        begin
            key_clamped = '0;
        end
        else if (key_wide > SCALE_S)
        begin
            key_clamped = SCALE_S[KEY_IN_W-1:0];
        end
        else
        begin
            key_clamped = key;
        end
    end

    assign rd_key   = rd_data_reg[ENTRY_W-1:COLOR_W];
    assign rd_color = rd_data_reg[COLOR_W-1:0];
    assign rd_key_s = $signed({1'b0, rd_key});
    assign idx_dec  = idx_reg - 1'b1;
    assign rd_addr  = cmd.rd_prev ? idx_dec[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign num      = key_reg[KEY_W-1:0] - prev_key_reg;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            shifted[ch] = {rem_reg[ch], dvd_reg[ch][PROD_W-1]};
            qbit[ch]    = (shifted[ch] >= {1'b0, den_reg});
            rem_next[ch] = qbit[ch] ? KEY_W'(shifted[ch] - {1'b0, den_reg})
                                    : shifted[ch][KEY_W-1:0];
            blend_color[ch*CH_W +: CH_W] = neg_reg[ch]
                ? base_reg[ch] - dvd_reg[ch][CH_W-1:0]
                : base_reg[ch] + dvd_reg[ch][CH_W-1:0];
        end
    end

    always_comb
    begin
        res_color  = '0;
        res_status = 1'b0;
        case (cmd.res_kind)
            RES_ZERO:  res_color = '0;
            RES_FULL:  res_status = 1'b1;
            RES_WHITE: res_color = WHITE;
            RES_STOP:  res_color = rd_color;
            RES_BLEND: res_color = blend_color;
            default:   res_color = '0;
        endcase
    end

    assign stat.op       = op_reg;
    assign stat.full     = (count_reg == CNT_W'(MAX_STOPS));
    assign stat.empty    = (count_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.idx_last = (idx_reg == count_reg - 1'b1);
    assign stat.rd_gt    = (rd_key_s > key_reg);
    assign stat.rd_eq    = (rd_key_s == key_reg);
    assign stat.div_last = (div_cnt_reg == '0);
    assign stat.out_free = !result_valid_reg || !result_stall;

    // Stop table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_move)
        begin
            mem[idx_reg[ADDR_W-1:0]] <= rd_data_reg;
        end
        else if (cmd.ins_place)
        begin
            mem[idx_reg[ADDR_W-1:0]] <= {key_reg[KEY_W-1:0], col_reg};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            key_reg <= (operation == OP_INSERT) ? key_clamped : key;
            col_reg <= stop_color;
        end
        if (cmd.ins_start)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.qry_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.ins_move)
        begin
            idx_reg <= idx_dec;
        end
        else if (cmd.qry_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.qry_step)
        begin
            prev_key_reg   <= rd_key;
            prev_color_reg <= rd_color;
        end
        if (cmd.mul)
        begin
            den_reg     <= rd_key - prev_key_reg;
            div_cnt_reg <= DIVC_W'(PROD_W - 1);
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                base_reg[ch] <= prev_color_reg[ch*CH_W +: CH_W];
                neg_reg[ch]  <= rd_color[ch*CH_W +: CH_W] < prev_color_reg[ch*CH_W +: CH_W];
                rem_reg[ch]  <= '0;
                if (rd_color[ch*CH_W +: CH_W] < prev_color_reg[ch*CH_W +: CH_W])
                begin
                    dvd_reg[ch] <= PROD_W'(prev_color_reg[ch*CH_W +: CH_W]
                                   - rd_color[ch*CH_W +: CH_W]) * PROD_W'(num);
                end
                else
                begin
                    dvd_reg[ch] <= PROD_W'(rd_color[ch*CH_W +: CH_W]
                                   - prev_color_reg[ch*CH_W +: CH_W]) * PROD_W'(num);
                end
            end
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                rem_reg[ch] <= rem_next[ch];
                dvd_reg[ch] <= {dvd_reg[ch][PROD_W-2:0], qbit[ch]};
            end
        end
        if (cmd.set_result)
        begin
            pend_color_reg  <= res_color;
            pend_status_reg <= res_status;
        end
        if (cmd.load_out)
        begin
            color_reg  <= pend_color_reg;
            status_reg <= pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.ins_place)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign color        = color_reg;
    assign status       = status_reg;

endmodule

[hw/rtl/color_gradient_interpolator_core.sv]
// Top level of the color gradient interpolator: controller plus datapath.
//
// Input channel (item_valid / item_stall) carries one beat per operation:
// clear, insert of a color stop, or query of a color at a key. The output
// channel (result_valid / result_stall) returns exactly one beat per input
// beat, in order, with the query color and the insert status.
// One operation is worked at a time. Clear, a full-table insert and an unused
// code go straight from dispatch to the result. An insert walks down the sorted
// table from the top, reading and comparing each stop and moving every larger
// stop up one slot until the new stop is placed. A query walks up the table
// through the stop memory, reading and comparing each stop in turn; an exact
// hit or an end stop answers with that stop's color, and interpolation adds
// the multiply and the 19-step dividers, one per channel. The next beat is
// taken in the cycle after the result is placed in the output register, even
// while that result still waits.
// Reset empties the table and drops any pending result. While the receiver
// stalls, the result register holds its beat and one finished result waits
// in the datapath before the controller stops.
module color_gradient_interpolator_core
    import cgi_pkg::*;
#(
    parameter int MAX_STOPS = 16,
    parameter int KEY_SCALE = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 operation,
    input  logic signed [KEY_IN_W-1:0] key,
    input  logic [COLOR_W-1:0]         stop_color,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [COLOR_W-1:0]         color,
    output logic                       status
);

    cgi_cmd_t    cmd;
    cgi_status_t stat;

    cgi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (stat),
        .cmd        (cmd)
    );

    cgi_datapath #(
        .MAX_STOPS (MAX_STOPS),
        .KEY_SCALE (KEY_SCALE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .key          (key),
        .stop_color   (stop_color),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .color        (color),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

    // A stop is never written into a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_place |-> !stat.full)
        else $error("stop placed into a full table");

    // A result is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result register overwritten");

    // After a beat is taken the block is busy until its result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second beat taken while busy");

    // Datapath actions on the table and the divider never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ins_move, cmd.ins_place, cmd.qry_step, cmd.mul, cmd.div_step}))
        else $error("conflicting datapath commands");

endmodule
